/* hw/rtl/vlcb_pkg.sv */
// shared types and constants for the vector length clamp pipeline
`default_nettype none

package vlcb_pkg;

  localparam int unsigned COORD_BITS = 24;
  localparam int unsigned ITERATIONS = 10;
  localparam int unsigned LIMIT_BITS = COORD_BITS - 1;
  localparam int unsigned SQ_BITS    = 2 * COORD_BITS;
  // one stage for the limit square, then a square stage and a select stage per step
  localparam int unsigned LATENCY    = 2 * ITERATIONS + 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [SQ_BITS-1:0]    sq_t;

  typedef struct packed {
    coord_t                x_in;
    coord_t                y_in;
    logic [LIMIT_BITS-1:0] max_length;
  } vlcb_req_t;

  typedef struct packed {
    coord_t x_out;
    coord_t y_out;
  } vlcb_rsp_t;

  // bisection state carried down the pipeline
  typedef struct packed {
    coord_t px;
    coord_t py;
    coord_t lo_x;
    coord_t lo_y;
    coord_t hi_x;
    coord_t hi_y;
    sq_t    lim_sq;
  } vlcb_pt_t;

  typedef struct packed {
    vlcb_pt_t pt;
    sq_t      sq_x;
    sq_t      sq_y;
  } vlcb_sq_t;

endpackage

`default_nettype wire

/* hw/rtl/vlcb_square.sv */
// squares the components of the current bisection point
`default_nettype none

module vlcb_square (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  vlcb_pkg::vlcb_pt_t pt_i,
  output logic               valid_o,
  output vlcb_pkg::vlcb_sq_t sq_o
);
  import vlcb_pkg::*;

  logic              valid_q;
  vlcb_sq_t          sq_q;
  vlcb_sq_t          sq_d;
  logic signed [SQ_BITS-1:0] prod_x;
  logic signed [SQ_BITS-1:0] prod_y;

  always_comb begin
    prod_x     = SQ_BITS'(pt_i.px) * SQ_BITS'(pt_i.px);
    prod_y     = SQ_BITS'(pt_i.py) * SQ_BITS'(pt_i.py);
    sq_d.pt    = pt_i;
    sq_d.sq_x  = sq_t'(prod_x);
    sq_d.sq_y  = sq_t'(prod_y);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q <= sq_d;
  end

  assign valid_o = valid_q;
  assign sq_o    = sq_q;

endmodule

`default_nettype wire

/* hw/rtl/vlcb_select.sv */
// compares the squared length with the limit, moves one end and takes the midpoint
`default_nettype none

module vlcb_select (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  vlcb_pkg::vlcb_sq_t sq_i,
  output logic               valid_o,
  output vlcb_pkg::vlcb_pt_t pt_o
);
  import vlcb_pkg::*;

  logic                     valid_q;
  vlcb_pt_t                 pt_q;
  vlcb_pt_t                 pt_d;
  sq_t                      len_sq;
  logic                     longer;
  logic signed [COORD_BITS:0] sum_x;
  logic signed [COORD_BITS:0] sum_y;

  always_comb begin
    // squares are at most 2^(SQ_BITS-2), so the sum cannot overflow
    len_sq = sq_i.sq_x + sq_i.sq_y;
    longer = len_sq > sq_i.pt.lim_sq;
    pt_d   = sq_i.pt;
    if (longer) begin
      pt_d.hi_x = sq_i.pt.px;
      pt_d.hi_y = sq_i.pt.py;
    end else begin
      pt_d.lo_x = sq_i.pt.px;
      pt_d.lo_y = sq_i.pt.py;
    end
    sum_x = {pt_d.hi_x[COORD_BITS-1], pt_d.hi_x} + {pt_d.lo_x[COORD_BITS-1], pt_d.lo_x};
    sum_y = {pt_d.hi_y[COORD_BITS-1], pt_d.hi_y} + {pt_d.lo_y[COORD_BITS-1], pt_d.lo_y};
    // floor of half the sum
    pt_d.px = sum_x[COORD_BITS:1];
    pt_d.py = sum_y[COORD_BITS:1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pt_q <= pt_d;
  end

  assign valid_o = valid_q;
  assign pt_o    = pt_q;

`ifndef ASSERT_OFF
  a_mid_x_between: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> ((pt_q.lo_x <= pt_q.px && pt_q.px <= pt_q.hi_x) ||
                 (pt_q.hi_x <= pt_q.px && pt_q.px <= pt_q.lo_x)))
    else $error("midpoint x outside bisection interval");
  a_mid_y_between: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> ((pt_q.lo_y <= pt_q.py && pt_q.py <= pt_q.hi_y) ||
                 (pt_q.hi_y <= pt_q.py && pt_q.py <= pt_q.lo_y)))
    else $error("midpoint y outside bisection interval");
`endif

endmodule

`default_nettype wire

/* hw/rtl/vector_length_clamp_bisection.sv */
// top level: vector length clamp by bisection, fully pipelined
//
// Usage:
//   request channel: drive req_i and raise start; the request is taken at a
//   rising edge where start is high and busy is low. busy is high only
//   from reset until the first clock edge after reset is released; after
//   that a request may be issued in every cycle.
//   result channel: rsp_o carries the clamped vector for exactly one cycle
//   while done_o is high. The receiver cannot stall, so results leave in
//   request order, one for every request.
//   stages: one stage squares the limit, then each bisection step is a
//   squaring stage followed by a compare, select and midpoint stage.
//   throughput: one request per cycle, set by the unrolled step pipeline.
//   reset: clears all valid bits, so nothing in flight is delivered.
`default_nettype none

module vector_length_clamp_bisection (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  vlcb_pkg::vlcb_req_t req_i,
  output logic                done_o,
  output vlcb_pkg::vlcb_rsp_t rsp_o
);
  import vlcb_pkg::*;

  logic     ready_q;
  logic     accept;
  logic     in_valid_q;
  vlcb_pt_t in_pt_q;
  vlcb_pt_t in_pt_d;

  logic     pt_valid [ITERATIONS+1];
  vlcb_pt_t pt       [ITERATIONS+1];
  logic     sq_valid [ITERATIONS];
  vlcb_sq_t sq       [ITERATIONS];

  assign accept = start & ready_q;
  assign busy   = ~ready_q;

  always_comb begin
    in_pt_d.px     = req_i.x_in;
    in_pt_d.py     = req_i.y_in;
    in_pt_d.hi_x   = req_i.x_in;
    in_pt_d.hi_y   = req_i.y_in;
    in_pt_d.lo_x   = '0;
    in_pt_d.lo_y   = '0;
    in_pt_d.lim_sq = sq_t'(req_i.max_length) * sq_t'(req_i.max_length);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q    <= 1'b0;
      in_valid_q <= 1'b0;
    end else begin
      ready_q    <= 1'b1;
      in_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    in_pt_q <= in_pt_d;
  end

  assign pt_valid[0] = in_valid_q;
  assign pt[0]       = in_pt_q;

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_step
    vlcb_square u_square (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (pt_valid[i]),
      .pt_i    (pt[i]),
      .valid_o (sq_valid[i]),
      .sq_o    (sq[i])
    );

    vlcb_select u_select (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sq_valid[i]),
      .sq_i    (sq[i]),
      .valid_o (pt_valid[i+1]),
      .pt_o    (pt[i+1])
    );
  end

  assign done_o      = pt_valid[ITERATIONS];
  assign rsp_o.x_out = pt[ITERATIONS].px;
  assign rsp_o.y_out = pt[ITERATIONS].py;

`ifndef ASSERT_OFF
  a_done_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o == $past(accept, LATENCY))
    else $error("result strobe does not match request latency");
  a_busy_stays_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |=> !busy)
    else $error("busy rose without reset");
`endif

endmodule

`default_nettype wire

/* test/vector_length_clamp_bisection_test.sv */
`timescale 1ns / 100ps
// testbench for the vector length clamp bisection pipeline: directed table, then random requests
module vector_length_clamp_bisection_test;
  import vlcb_pkg::*;

  typedef logic [LIMIT_BITS-1:0] lim_t;

  typedef struct packed {
    logic   known;
    coord_t x;
    coord_t y;
    lim_t   lim;
    coord_t ex;
    coord_t ey;
  } clamp_row_t;

  localparam coord_t C_MAX = 24'sh7fffff;
  localparam coord_t C_MIN = 24'sh800000;
  localparam coord_t C_0   = 24'sd0;
  localparam lim_t   L_MAX = 23'h7fffff;
  localparam lim_t   L_0   = 23'd0;

  localparam int unsigned ITEMS_PER_PHASE = 300;
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned N_ROWS          = 23;

  // known rows carry the expected vector; the rest go through the predictor
  localparam clamp_row_t CLAMP_TABLE [N_ROWS] = '{
    '{1'b1, C_0, C_0, L_0, C_0, C_0},
    '{1'b1, 24'sd12288, 24'sd16384, 23'd20480, 24'sd12288, 24'sd16384},
    '{1'b1, 24'sd12288, 24'sd16384, 23'd40960, 24'sd12288, 24'sd16384},
    '{1'b0, 24'sd24576, 24'sd32768, 23'd20480, C_0, C_0},
    '{1'b1, 24'sd1, C_0, L_0, C_0, C_0},
    '{1'b1, -24'sd1, C_0, L_0, -24'sd1, C_0},
    '{1'b1, C_0, -24'sd1, L_0, C_0, -24'sd1},
    '{1'b1, C_MIN, C_MIN, L_0, -24'sd8192, -24'sd8192},
    '{1'b1, C_MAX, C_MAX, L_0, 24'sd8191, 24'sd8191},
    '{1'b0, C_MAX, C_MAX, L_MAX, C_0, C_0},
    '{1'b0, C_MIN, C_MIN, L_MAX, C_0, C_0},
    '{1'b0, C_MIN, C_0, L_MAX, C_0, C_0},
    '{1'b1, C_MAX, C_0, L_MAX, C_MAX, C_0},
    '{1'b0, C_0, C_MIN, L_MAX, C_0, C_0},
    '{1'b1, C_MIN, C_MAX, L_0, -24'sd8192, 24'sd8191},
    '{1'b1, 24'sd1, 24'sd1, L_0, C_0, C_0},
    '{1'b0, -24'sd4096, 24'sd4096, 23'd4096, C_0, C_0},
    '{1'b1, 24'sd4096, C_0, 23'd4096, 24'sd4096, C_0},
    '{1'b0, 24'sd4097, C_0, 23'd4096, C_0, C_0},
    '{1'b0, -24'sd300000, 24'sd250000, 23'd100000, C_0, C_0},
    '{1'b0, 24'sd5, -24'sd7, 23'd1, C_0, C_0},
    '{1'b0, 24'sh555555, 24'shaaaaaa, 23'h2aaaaa, C_0, C_0},
    '{1'b0, 24'shaaaaaa, 24'sh555555, 23'h555555, C_0, C_0}
  };

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  vlcb_req_t req_i;
  logic      done_o;
  vlcb_rsp_t rsp_o;

  vlcb_rsp_t   clamp_expected [$];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned sender_idle_pct;
  int unsigned idle_phases [4] = '{0, 82, 0, 13};

  vector_length_clamp_bisection dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic vlcb_rsp_t clamp_by_bisection(vlcb_req_t r);
    longint    px, py, lo_x, lo_y, hi_x, hi_y, lim_sq, len_sq;
    int        step;
    vlcb_rsp_t res;
    px     = longint'($signed(r.x_in));
    py     = longint'($signed(r.y_in));
    lim_sq = longint'(r.max_length) * longint'(r.max_length);
    lo_x   = 0;
    lo_y   = 0;
    hi_x   = px;
    hi_y   = py;
    for (step = 0; step < ITERATIONS; step++) begin
      len_sq = px * px + py * py;
      // equal length counts as inside the limit
      if (len_sq > lim_sq) begin
        hi_x = px;
        hi_y = py;
      end else begin
        lo_x = px;
        lo_y = py;
      end
      px = (hi_x + lo_x) >>> 1;
      py = (hi_y + lo_y) >>> 1;
    end
    res.x_out = px[COORD_BITS-1:0];
    res.y_out = py[COORD_BITS-1:0];
    return res;
  endfunction

  function automatic coord_t scaled_coord();
    coord_t c;
    c = coord_t'($urandom);
    return c >>> $urandom_range(0, 20);
  endfunction

  function automatic vlcb_req_t random_request();
    vlcb_req_t r;
    longint    ax, ay, lo_b, hi_b;
    int        sx, sy;
    r.x_in       = scaled_coord();
    r.y_in       = scaled_coord();
    r.max_length = lim_t'($urandom);
    ax = longint'(r.x_in);
    ay = longint'(r.y_in);
    if (ax < 0) ax = -ax;
    if (ay < 0) ay = -ay;
    case ($urandom_range(0, 7))
      0: begin
        r.x_in = coord_t'($urandom);
        r.y_in = coord_t'($urandom);
      end
      1, 2, 3: begin
        // limit between the larger component and the sum: close to the true length
        lo_b = (ax > ay) ? ax : ay;
        hi_b = ax + ay;
        if (hi_b > longint'(L_MAX)) hi_b = longint'(L_MAX);
        if (lo_b > hi_b) lo_b = hi_b;
        r.max_length = lim_t'($urandom_range(int'(lo_b), int'(hi_b)));
      end
      4: r.max_length = lim_t'($urandom) >> $urandom_range(0, 22);
      5: begin
        sx = int'($urandom_range(0, 128)) - 64;
        sy = int'($urandom_range(0, 128)) - 64;
        r.x_in       = coord_t'(sx);
        r.y_in       = coord_t'(sy);
        r.max_length = lim_t'($urandom_range(0, 100));
      end
      6: begin
        r.max_length = ($urandom_range(0, 1) == 0) ? L_0 : L_MAX;
        if ($urandom_range(0, 1) == 0) r.x_in = ($urandom_range(0, 1) == 0) ? C_MIN : C_MAX;
        if ($urandom_range(0, 1) == 0) r.y_in = ($urandom_range(0, 1) == 0) ? C_MIN : C_MAX;
      end
      default: begin
        // on an axis, limit at the length or one step either side
        r.y_in = C_0;
        lo_b   = ax + longint'($urandom_range(0, 2)) - 1;
        if (lo_b < 0) lo_b = 0;
        if (lo_b > longint'(L_MAX)) lo_b = longint'(L_MAX);
        r.max_length = lo_b[LIMIT_BITS-1:0];
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  task automatic issue_request(input vlcb_req_t r, input logic known, input vlcb_rsp_t want);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      req_i <= '{x_in: coord_t'($urandom), y_in: coord_t'($urandom),
                 max_length: lim_t'($urandom)};
      @(negedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    clamp_expected.push_back(known ? want : clamp_by_bisection(r));
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (clamp_expected.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin : check_results
    vlcb_rsp_t want;
    if (rst_ni && done_o) begin
      if (clamp_expected.size() == 0) begin
        report_mismatch("result with no request pending, x_out", longint'(rsp_o.x_out), 0);
      end else begin
        want = clamp_expected.pop_front();
        if (rsp_o.x_out !== want.x_out)
          report_mismatch("x_out", longint'(rsp_o.x_out), longint'(want.x_out));
        if (rsp_o.y_out !== want.y_out)
          report_mismatch("y_out", longint'(rsp_o.y_out), longint'(want.y_out));
      end
    end
  end

  initial begin : stimulus
    vlcb_req_t dir_req;
    vlcb_rsp_t dir_rsp;
    int        i;
    int        phase;
    start           = 1'b0;
    req_i           = '0;
    rst_ni          = 1'b0;
    sender_idle_pct = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (i = 0; i < N_ROWS; i++) begin
      dir_req = '{x_in: CLAMP_TABLE[i].x, y_in: CLAMP_TABLE[i].y,
                  max_length: CLAMP_TABLE[i].lim};
      dir_rsp = '{x_out: CLAMP_TABLE[i].ex, y_out: CLAMP_TABLE[i].ey};
      issue_request(dir_req, CLAMP_TABLE[i].known, dir_rsp);
    end
    wait_drained();

    // sender holds off after each phase until the pipeline is empty
    for (phase = 0; phase < 4; phase++) begin
      sender_idle_pct = idle_phases[phase];
      repeat (ITEMS_PER_PHASE) issue_request(random_request(), 1'b0, '0);
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
